// ===== hw/rtl/rfs_pkg.sv =====
package rfs_pkg;

  localparam int WordBits         = 16;
  localparam int SlotIdxBits      = 4;
  localparam int ChanBits         = 5;
  localparam int DelayBits        = 8;
  localparam int AddrBits         = 16;
  localparam int NumSlotsDefault  = 16;
  localparam int FbBitsDefault    = 16;

  typedef enum logic [1:0] {
    FuncTick     = 2'd0,
    FuncFeedback = 2'd1,
    FuncStart    = 2'd2,
    FuncStop     = 2'd3
  } func_e;

  // one input item as held in the input register
  typedef struct packed {
    func_e                  func;
    logic [SlotIdxBits-1:0] device_slot;
    logic                   use_feedback;
    logic [ChanBits-1:0]    feedback_channel;
    logic [DelayBits-1:0]   delay_ticks;
    logic [AddrBits-1:0]    register_address;
    logic [WordBits-1:0]    feedback_word;
  } item_t;

  // event broadcast to every slot cell
  typedef struct packed {
    logic                 fire;
    func_e                func;
    logic                 use_feedback;
    logic [ChanBits-1:0]  chan;
    logic [DelayBits-1:0] delay;
    logic                 addr_ok;
    logic [WordBits-1:0]  word;
    logic [WordBits-1:0]  last_word;
  } evt_t;

  typedef struct packed {
    logic fault;
    logic active;
    logic monitoring;
  } slot_stat_t;

endpackage

// ===== hw/rtl/rfs_if.sv =====
interface rfs_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          func;
  logic [rfs_pkg::SlotIdxBits-1:0]     device_slot;
  logic                                use_feedback;
  logic [rfs_pkg::ChanBits-1:0]        feedback_channel;
  logic [rfs_pkg::DelayBits-1:0]       delay_ticks;
  logic [rfs_pkg::AddrBits-1:0]        register_address;
  logic [rfs_pkg::WordBits-1:0]        feedback_word;

  modport source (
    output valid, func, device_slot, use_feedback, feedback_channel, delay_ticks,
           register_address, feedback_word,
    input  ready
  );
  modport sink (
    input  valid, func, device_slot, use_feedback, feedback_channel, delay_ticks,
           register_address, feedback_word,
    output ready
  );
endinterface

interface rfs_out_if;
  logic                        valid;
  logic                        ready;
  logic [rfs_pkg::WordBits-1:0] fault_mask;
  logic [rfs_pkg::WordBits-1:0] monitoring_mask;
  logic [rfs_pkg::WordBits-1:0] waiting_mask;

  modport source (
    output valid, fault_mask, monitoring_mask, waiting_mask,
    input  ready
  );
  modport sink (
    input  valid, fault_mask, monitoring_mask, waiting_mask,
    output ready
  );
endinterface

// ===== hw/rtl/run_feedback_supervisor.sv =====
// channel | dir | payload
// in_i    | in  | func, device_slot, use_feedback, feedback_channel, delay_ticks,
//         |     | register_address, feedback_word
// out_o   | out | fault_mask, monitoring_mask, waiting_mask
//
// one item per cycle sustained while out_o accepts results; the result passes through
// the input register, then all slot cells update in parallel into the result register
// every item gives exactly one result; the input side stalls only when both the
// input register and the result register are full and out_o is not ready
// asynchronous active-low reset clears all slots and the stored feedback word
module run_feedback_supervisor #(
  parameter int NUM_SLOTS     = rfs_pkg::NumSlotsDefault,
  parameter int FEEDBACK_BITS = rfs_pkg::FbBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rfs_in_if.sink    in_i,
  rfs_out_if.source out_o
);

  localparam int MaskSlots = (NUM_SLOTS < rfs_pkg::WordBits) ? NUM_SLOTS : rfs_pkg::WordBits;

  rfs_pkg::item_t              item_q;
  logic                        item_valid_q;
  logic                        adv;
  logic [rfs_pkg::WordBits-1:0] last_word_q;
  logic                        out_valid_q;
  logic [rfs_pkg::WordBits-1:0] fault_q, fault_d;
  logic [rfs_pkg::WordBits-1:0] mon_q, mon_d;
  logic [rfs_pkg::WordBits-1:0] wait_q, wait_d;
  rfs_pkg::evt_t               evt;
  rfs_pkg::slot_stat_t         stat [NUM_SLOTS];

  assign adv        = item_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !item_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      item_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.func             <= rfs_pkg::func_e'(in_i.func);
      item_q.device_slot      <= in_i.device_slot;
      item_q.use_feedback     <= in_i.use_feedback;
      item_q.feedback_channel <= in_i.feedback_channel;
      item_q.delay_ticks      <= in_i.delay_ticks;
      item_q.register_address <= in_i.register_address;
      item_q.feedback_word    <= in_i.feedback_word;
    end
  end

  assign evt.fire         = adv;
  assign evt.func         = item_q.func;
  assign evt.use_feedback = item_q.use_feedback;
  assign evt.chan         = item_q.feedback_channel;
  assign evt.delay        = item_q.delay_ticks;
  assign evt.addr_ok      = (item_q.register_address == '0);
  assign evt.word         = item_q.feedback_word;
  assign evt.last_word    = last_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_word_q <= '0;
    end else if (adv && item_q.func == rfs_pkg::FuncFeedback && evt.addr_ok) begin
      last_word_q <= item_q.feedback_word;
    end
  end

  for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_slot
    rfs_slot #(
      .FEEDBACK_BITS(FEEDBACK_BITS)
    ) u_slot (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .evt_i (evt),
      .hit_i (int'(item_q.device_slot) == s),
      .stat_o(stat[s])
    );
  end

  // slots past the mask width never show up in the result
  always_comb begin
    fault_d = '0;
    mon_d   = '0;
    wait_d  = '0;
    for (int s = 0; s < MaskSlots; s++) begin
      fault_d[s] = stat[s].fault;
      mon_d[s]   = stat[s].active && stat[s].monitoring;
      wait_d[s]  = stat[s].active && !stat[s].monitoring;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fault_q <= fault_d;
      mon_q   <= mon_d;
      wait_q  <= wait_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.fault_mask      = fault_q;
  assign out_o.monitoring_mask = mon_q;
  assign out_o.waiting_mask    = wait_q;

endmodule

// ===== hw/rtl/rfs_slot.sv =====
module rfs_slot #(
  parameter int FEEDBACK_BITS = rfs_pkg::FbBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rfs_pkg::evt_t       evt_i,
  input  logic                hit_i,
  output rfs_pkg::slot_stat_t stat_o
);

  logic                            active_q, active_d;
  logic                            mon_q, mon_d;
  logic                            last_q, last_d;
  logic [rfs_pkg::ChanBits-1:0]    chan_q, chan_d;
  logic [rfs_pkg::DelayBits-1:0]   cnt_q, cnt_d;
  logic                            chan_ok;
  logic                            bit_now;
  logic                            bit_old;
  logic                            fault;

  // channels past the word or past the populated inputs read low
  assign chan_ok = (chan_q < rfs_pkg::ChanBits'(rfs_pkg::WordBits)) &&
                   (int'(chan_q) < FEEDBACK_BITS);
  assign bit_now = chan_ok && evt_i.word[chan_q[3:0]];
  assign bit_old = chan_ok && evt_i.last_word[chan_q[3:0]];

  always_comb begin
    active_d = active_q;
    mon_d    = mon_q;
    last_d   = last_q;
    chan_d   = chan_q;
    cnt_d    = cnt_q;
    fault    = 1'b0;
    if (evt_i.fire) begin
      case (evt_i.func)
        rfs_pkg::FuncTick: begin
          if (active_q && !mon_q) begin
            if (cnt_q <= rfs_pkg::DelayBits'(1)) begin
              if (bit_old) begin
                mon_d  = 1'b1;
                last_d = 1'b1;
                cnt_d  = '0;
              end else begin
                fault    = 1'b1;
                active_d = 1'b0;
                mon_d    = 1'b0;
                last_d   = 1'b0;
                chan_d   = '0;
                cnt_d    = '0;
              end
            end else begin
              cnt_d = cnt_q - rfs_pkg::DelayBits'(1);
            end
          end
        end
        rfs_pkg::FuncFeedback: begin
          if (evt_i.addr_ok && active_q) begin
            if (!mon_q) begin
              if (bit_now) begin
                mon_d  = 1'b1;
                last_d = 1'b1;
                cnt_d  = '0;
              end
            end else if (last_q && !bit_now) begin
              // watched bit fell while running
              fault    = 1'b1;
              active_d = 1'b0;
              mon_d    = 1'b0;
              last_d   = 1'b0;
              chan_d   = '0;
              cnt_d    = '0;
            end else begin
              last_d = bit_now;
            end
          end
        end
        rfs_pkg::FuncStart: begin
          if (hit_i && evt_i.use_feedback) begin
            active_d = 1'b1;
            mon_d    = 1'b0;
            last_d   = 1'b0;
            chan_d   = evt_i.chan;
            cnt_d    = evt_i.delay;
          end
        end
        rfs_pkg::FuncStop: begin
          if (hit_i) begin
            active_d = 1'b0;
            mon_d    = 1'b0;
            last_d   = 1'b0;
            chan_d   = '0;
            cnt_d    = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      mon_q    <= 1'b0;
      last_q   <= 1'b0;
      chan_q   <= '0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      mon_q    <= mon_d;
      last_q   <= last_d;
      chan_q   <= chan_d;
      cnt_q    <= cnt_d;
    end
  end

  assign stat_o.fault      = fault;
  assign stat_o.active     = active_d;
  assign stat_o.monitoring = mon_d;

endmodule

// ===== tb/run_feedback_supervisor_test.sv =====
module run_feedback_supervisor_test;

  localparam int Slots = rfs_pkg::NumSlotsDefault;
  localparam int WatchdogLimit = 4000;

  typedef struct packed {
    logic [rfs_pkg::WordBits-1:0] fault;
    logic [rfs_pkg::WordBits-1:0] monitoring;
    logic [rfs_pkg::WordBits-1:0] waiting;
  } masks_t;

  logic clk_i;
  logic rst_ni;

  rfs_in_if  in_if ();
  rfs_out_if out_if ();

  run_feedback_supervisor u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // shadow copy of the supervisor state
  logic                          sv_active [Slots];
  logic                          sv_mon    [Slots];
  logic                          sv_last   [Slots];
  logic [rfs_pkg::ChanBits-1:0]  sv_chan   [Slots];
  logic [rfs_pkg::DelayBits-1:0] sv_count  [Slots];
  logic [rfs_pkg::WordBits-1:0]  sv_word;

  rfs_pkg::item_t stim_q [$];
  masks_t         status_q [$];
  rfs_pkg::item_t cur_item;

  int   n_items = 0;
  int   n_taken = 0;
  int   n_checked = 0;
  int   n_faults = 0;
  int   n_mon_results = 0;
  int   errors = 0;
  int   cyc = 0;
  int   idle_cyc = 0;
  logic in_taken = 1'b0;
  logic calm;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // channels at or above the feedback width always read zero
  function automatic logic chan_bit(logic [rfs_pkg::WordBits-1:0] w,
                                    logic [rfs_pkg::ChanBits-1:0] ch);
    if (ch >= rfs_pkg::WordBits || ch >= rfs_pkg::FbBitsDefault) return 1'b0;
    return w[ch[rfs_pkg::SlotIdxBits-1:0]];
  endfunction

  function automatic void drop_slot(int s);
    sv_active[s] = 1'b0;
    sv_mon[s]    = 1'b0;
    sv_last[s]   = 1'b0;
    sv_chan[s]   = '0;
    sv_count[s]  = '0;
  endfunction

  function automatic masks_t supervise_item(rfs_pkg::item_t it);
    masks_t r;
    logic   b;
    int     s;
    r = '0;
    case (it.func)
      rfs_pkg::FuncTick: begin
        for (s = 0; s < Slots; s++) begin
          if (sv_active[s] && !sv_mon[s]) begin
            if (sv_count[s] <= 1) begin
              // timeout: stored word decides
              if (chan_bit(sv_word, sv_chan[s])) begin
                sv_mon[s]   = 1'b1;
                sv_last[s]  = 1'b1;
                sv_count[s] = '0;
              end else begin
                r.fault[s] = 1'b1;
                drop_slot(s);
              end
            end else begin
              sv_count[s] = sv_count[s] - 1'b1;
            end
          end
        end
      end
      rfs_pkg::FuncFeedback: begin
        if (it.register_address == '0) begin
          sv_word = it.feedback_word;
          for (s = 0; s < Slots; s++) begin
            if (sv_active[s]) begin
              b = chan_bit(it.feedback_word, sv_chan[s]);
              if (!sv_mon[s]) begin
                if (b) begin
                  sv_mon[s]   = 1'b1;
                  sv_last[s]  = 1'b1;
                  sv_count[s] = '0;
                end
              end else if (sv_last[s] && !b) begin
                r.fault[s] = 1'b1;
                drop_slot(s);
              end else begin
                sv_last[s] = b;
              end
            end
          end
        end
      end
      rfs_pkg::FuncStart: begin
        if (it.use_feedback) begin
          drop_slot(int'(it.device_slot));
          sv_active[it.device_slot] = 1'b1;
          sv_chan[it.device_slot]   = it.feedback_channel;
          sv_count[it.device_slot]  = it.delay_ticks;
        end
      end
      default: drop_slot(int'(it.device_slot));
    endcase
    for (s = 0; s < Slots; s++) begin
      if (sv_active[s]) begin
        if (sv_mon[s]) r.monitoring[s] = 1'b1;
        else r.waiting[s] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic rfs_pkg::item_t make_item(rfs_pkg::func_e f, int slot, bit use_fb,
                                               int ch, int dly, int addr, int word);
    rfs_pkg::item_t it;
    it.func             = f;
    it.device_slot      = rfs_pkg::SlotIdxBits'(slot);
    it.use_feedback     = use_fb;
    it.feedback_channel = rfs_pkg::ChanBits'(ch);
    it.delay_ticks      = rfs_pkg::DelayBits'(dly);
    it.register_address = rfs_pkg::AddrBits'(addr);
    it.feedback_word    = rfs_pkg::WordBits'(word);
    return it;
  endfunction

  function automatic rfs_pkg::item_t random_item();
    rfs_pkg::item_t it;
    int             pick;
    it.device_slot      = rfs_pkg::SlotIdxBits'($urandom_range(Slots - 1));
    it.use_feedback     = ($urandom_range(99) < 90);
    it.feedback_channel = ($urandom_range(99) < 90) ?
                          rfs_pkg::ChanBits'($urandom_range(15)) :
                          rfs_pkg::ChanBits'($urandom_range(31, 16));
    it.delay_ticks      = ($urandom_range(99) < 85) ?
                          rfs_pkg::DelayBits'($urandom_range(6)) :
                          rfs_pkg::DelayBits'($urandom_range(255));
    it.register_address = rfs_pkg::AddrBits'($urandom_range(65535));
    pick = $urandom_range(99);
    // mostly-ones words keep monitoring slots alive for a while
    if (pick < 45) it.feedback_word = rfs_pkg::WordBits'($urandom);
    else if (pick < 90) it.feedback_word = rfs_pkg::WordBits'($urandom | $urandom | $urandom);
    else if (pick < 95) it.feedback_word = '0;
    else it.feedback_word = '1;
    pick = $urandom_range(99);
    if (pick < 35) begin
      it.func = rfs_pkg::FuncTick;
    end else if (pick < 65) begin
      it.func = rfs_pkg::FuncFeedback;
      if ($urandom_range(99) < 90) it.register_address = '0;
      else it.register_address = rfs_pkg::AddrBits'($urandom_range(65535, 1));
    end else if (pick < 90) begin
      it.func = rfs_pkg::FuncStart;
    end else begin
      it.func = rfs_pkg::FuncStop;
    end
    return it;
  endfunction

  task automatic note_mismatch(string what, logic [rfs_pkg::WordBits-1:0] got,
                               logic [rfs_pkg::WordBits-1:0] want);
    errors++;
    $display("mismatch at result %0d: %s got %h want %h", n_checked, what, got, want);
  endtask

  // driver: new item once the current one is taken, inputs move on the falling edge
  always @(negedge clk_i) begin
    calm = (cyc >= 900 && cyc < 1500);
    if (rst_ni) begin
      if (!in_if.valid || in_taken) begin
        if (stim_q.size() != 0 && (calm || $urandom_range(99) >= 27)) begin
          cur_item = stim_q.pop_front();
          in_if.valid            <= 1'b1;
          in_if.func             <= cur_item.func;
          in_if.device_slot      <= cur_item.device_slot;
          in_if.use_feedback     <= cur_item.use_feedback;
          in_if.feedback_channel <= cur_item.feedback_channel;
          in_if.delay_ticks      <= cur_item.delay_ticks;
          in_if.register_address <= cur_item.register_address;
          in_if.feedback_word    <= cur_item.feedback_word;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= calm || ($urandom_range(99) >= 27);
    end
  end

  // monitor: sample both channels on the rising edge
  always @(posedge clk_i) begin
    masks_t         got;
    masks_t         want;
    rfs_pkg::item_t seen;
    logic           out_taken;
    if (rst_ni) begin
      cyc++;
      out_taken = out_if.valid && out_if.ready;
      if (out_taken) begin
        got = {out_if.fault_mask, out_if.monitoring_mask, out_if.waiting_mask};
        if (status_q.size() == 0) begin
          note_mismatch("result with nothing pending, fault_mask", got.fault, '0);
        end else begin
          want = status_q.pop_front();
          if (got.fault != want.fault) note_mismatch("fault_mask", got.fault, want.fault);
          if (got.monitoring != want.monitoring)
            note_mismatch("monitoring_mask", got.monitoring, want.monitoring);
          if (got.waiting != want.waiting)
            note_mismatch("waiting_mask", got.waiting, want.waiting);
          n_checked++;
          n_faults += $countones(got.fault);
          if (got.monitoring != '0) n_mon_results++;
        end
      end
      in_taken = in_if.valid && in_if.ready;
      if (in_taken) begin
        seen.func             = rfs_pkg::func_e'(in_if.func);
        seen.device_slot      = in_if.device_slot;
        seen.use_feedback     = in_if.use_feedback;
        seen.feedback_channel = in_if.feedback_channel;
        seen.delay_ticks      = in_if.delay_ticks;
        seen.register_address = in_if.register_address;
        seen.feedback_word    = in_if.feedback_word;
        status_q.push_back(supervise_item(seen));
        n_taken++;
      end
      if (in_taken || out_taken) idle_cyc = 0;
      else idle_cyc++;
      if (idle_cyc >= WatchdogLimit) begin
        $display("watchdog: no handshake for %0d cycles", idle_cyc);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int k;
    rst_ni                 = 1'b0;
    in_if.valid            = 1'b0;
    in_if.func             = '0;
    in_if.device_slot      = '0;
    in_if.use_feedback     = 1'b0;
    in_if.feedback_channel = '0;
    in_if.delay_ticks      = '0;
    in_if.register_address = '0;
    in_if.feedback_word    = '0;
    out_if.ready           = 1'b0;
    for (k = 0; k < Slots; k++) drop_slot(k);
    sv_word = '0;

    // zero delay expires on the first tick with an empty stored word
    stim_q.push_back(make_item(rfs_pkg::FuncStart, 0, 1, 0, 0, 0, 0));
    stim_q.push_back(make_item(rfs_pkg::FuncTick, 0, 0, 0, 0, 0, 0));
    // start without feedback is a no-op
    stim_q.push_back(make_item(rfs_pkg::FuncStart, 3, 0, 7, 9, 0, 0));
    stim_q.push_back(make_item(rfs_pkg::FuncStart, 15, 1, 31, 255, 0, 0));
    // wrong register is ignored, out of range channel never sees a one
    stim_q.push_back(make_item(rfs_pkg::FuncFeedback, 0, 0, 0, 0, 16'hffff, 16'hffff));
    stim_q.push_back(make_item(rfs_pkg::FuncFeedback, 0, 0, 0, 0, 0, 16'hffff));
    stim_q.push_back(make_item(rfs_pkg::FuncStop, 4, 0, 0, 0, 0, 0));
    // feedback seen early, then the watched bit drops
    stim_q.push_back(make_item(rfs_pkg::FuncStart, 1, 1, 15, 2, 0, 0));
    stim_q.push_back(make_item(rfs_pkg::FuncFeedback, 0, 0, 0, 0, 0, 16'h8000));
    stim_q.push_back(make_item(rfs_pkg::FuncFeedback, 0, 0, 0, 0, 0, 16'h8000));
    stim_q.push_back(make_item(rfs_pkg::FuncFeedback, 0, 0, 0, 0, 0, 16'h0000));
    // timeout with the stored bit already set goes to monitoring
    stim_q.push_back(make_item(rfs_pkg::FuncFeedback, 0, 0, 0, 0, 0, 16'h0008));
    stim_q.push_back(make_item(rfs_pkg::FuncStart, 2, 1, 3, 1, 0, 0));
    stim_q.push_back(make_item(rfs_pkg::FuncTick, 0, 0, 0, 0, 0, 0));
    stim_q.push_back(make_item(rfs_pkg::FuncStart, 5, 1, 16, 3, 0, 0));
    stim_q.push_back(make_item(rfs_pkg::FuncTick, 0, 0, 0, 0, 0, 0));
    stim_q.push_back(make_item(rfs_pkg::FuncTick, 0, 0, 0, 0, 0, 0));
    stim_q.push_back(make_item(rfs_pkg::FuncTick, 0, 0, 0, 0, 0, 0));
    // restart of a monitoring slot puts it back to waiting
    stim_q.push_back(make_item(rfs_pkg::FuncStart, 2, 1, 0, 4, 0, 0));
    stim_q.push_back(make_item(rfs_pkg::FuncStop, 15, 0, 0, 0, 0, 0));
    stim_q.push_back(make_item(rfs_pkg::FuncFeedback, 0, 0, 0, 0, 0, 16'h0001));
    stim_q.push_back(make_item(rfs_pkg::FuncFeedback, 0, 0, 0, 0, 0, 16'hfffe));
    stim_q.push_back(make_item(rfs_pkg::FuncStart, 9, 1, 10, 255, 16'hffff, 16'hffff));
    stim_q.push_back(make_item(rfs_pkg::FuncStop, 9, 1, 31, 255, 16'hffff, 16'hffff));

    while (stim_q.size() < 1650) stim_q.push_back(random_item());
    n_items = stim_q.size();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (n_taken < n_items || status_q.size() != 0) @(negedge clk_i);
    repeat (12) @(posedge clk_i);

    $display("%0d events applied, %0d results checked, %0d errors", n_taken, n_checked, errors);
    $display("%0d slot faults reported, %0d results with slots in monitoring",
             n_faults, n_mon_results);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rfs_pkg.sv
hw/rtl/rfs_if.sv
hw/rtl/rfs_slot.sv
hw/rtl/run_feedback_supervisor.sv
tb/run_feedback_supervisor_test.sv
